FILE: rtl/moma_pkg.sv
// Package for the median-of-means accumulator: sizes, field types, queue entry.
// No dependencies.
package moma_pkg;
    localparam int unsigned Buckets    = 20;
    localparam int unsigned Entries    = 1024;
    localparam int unsigned PixW       = 10;
    localparam int unsigned BktW       = 5;
    localparam int unsigned SampW      = 32;
    localparam int unsigned SumW       = 48;
    localparam int unsigned CntW       = 16;
    localparam int unsigned RamDepth   = Entries * Buckets;
    localparam int unsigned AddrW      = $clog2(RamDepth);
    localparam int unsigned BIdxW      = $clog2(Buckets + 1);
    localparam int unsigned MeanW      = 32;
    localparam int unsigned QDepth     = 2;
    localparam int unsigned StepW      = $clog2(SumW + 1);

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_BADQ   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PixW-1:0]  pix;
        logic [AddrW-1:0] addr;
        logic [SampW-1:0] sample;
    } t_cmd;

    localparam logic [SumW-1:0] SumMax  = {SumW{1'b1}};
    localparam logic [CntW-1:0] CntMax  = {CntW{1'b1}};
endpackage

FILE: rtl/moma_if.sv
// Valid/ready channel interfaces for the accumulator.
// Depends on moma_pkg.
interface moma_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [moma_pkg::PixW-1:0]    pixel_index;
    logic [moma_pkg::BktW-1:0]    bucket;
    logic [moma_pkg::SampW-1:0]   sample_value;
    modport source (output valid, mode, pixel_index, bucket, sample_value, input ready);
    modport sink   (input valid, mode, pixel_index, bucket, sample_value, output ready);
endinterface

interface moma_out_if;
    logic                         valid;
    logic                         ready;
    logic [moma_pkg::PixW-1:0]    pixel_index_out;
    logic [moma_pkg::MeanW-1:0]   median;
    logic                         empty_bucket;
    modport source (output valid, pixel_index_out, median, empty_bucket, input ready);
    modport sink   (input valid, pixel_index_out, median, empty_bucket, output ready);
endinterface

FILE: rtl/median_of_means_accumulator.sv
// Top level of the median-of-means accumulator: front queue plus back engine.
// Depends on moma_pkg, moma_if, moma_front, moma_back.
//
//  channel  dir  handshake    payload
//  in_ch    in   valid/ready  mode, pixel_index, bucket, sample_value
//  out_ch   out  valid/ready  pixel_index_out, median, empty_bucket
//
// Insert: the back end reads the entry (S_RD), then writes the saturated update (S_WR).
// Query: per bucket a read, a bit-serial divide (skipped for an empty bucket) and
// insertion-sort steps, then the median of the sorted bucket means is output.
// After reset a clearing pass writes all 20480 RAM entries; no input transfer meanwhile.
// The two-entry queue keeps taking items while the back end or output stalls, until it is full.
module median_of_means_accumulator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    moma_in_if.sink    in_ch,
    moma_out_if.source out_ch
);
    logic           cmd_valid, pop, clr_busy;
    moma_pkg::t_cmd cmd;

    moma_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .i_clr_busy(clr_busy),
        .i_pop(pop), .o_cmd_valid(cmd_valid), .o_cmd(cmd));
    moma_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_pop(pop), .o_clr_busy(clr_busy), .out_ch(out_ch));

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !in_ch.ready) else $error("transfer during clear");
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cmd_valid) else $error("pop from empty queue");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
endmodule

FILE: rtl/moma_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module moma_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/moma_front.sv
// Front end: classifies input items into commands and holds them in a short queue.
// Depends on moma_pkg, moma_if.
module moma_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    moma_in_if.sink              in_ch,
    input  logic                 i_clr_busy,
    input  logic                 i_pop,
    output logic                 o_cmd_valid,
    output moma_pkg::t_cmd       o_cmd
);
    moma_pkg::t_cmd r_q [moma_pkg::QDepth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    moma_pkg::t_cmd n_cmd;
    logic push;
    logic [moma_pkg::AddrW-1:0] base;

    assign in_ch.ready = !i_clr_busy && (r_cnt != 2'(moma_pkg::QDepth));
    assign push = in_ch.valid && in_ch.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_comb begin
        base = moma_pkg::AddrW'(in_ch.pixel_index) * moma_pkg::AddrW'(moma_pkg::Buckets);
        n_cmd.pix = in_ch.pixel_index;
        n_cmd.sample = in_ch.sample_value;
        n_cmd.addr = base + moma_pkg::AddrW'(in_ch.bucket);
        if (in_ch.mode) begin
            n_cmd.addr = base;
            if (32'(in_ch.pixel_index) >= moma_pkg::Entries) n_cmd.op = moma_pkg::OP_BADQ;
            else n_cmd.op = moma_pkg::OP_QUERY;
        end else if (32'(in_ch.pixel_index) >= moma_pkg::Entries
                     || 32'(in_ch.bucket) >= moma_pkg::Buckets) begin
            n_cmd.op = moma_pkg::OP_NONE;
        end else begin
            n_cmd.op = moma_pkg::OP_INSERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

FILE: rtl/moma_div.sv
// Radix-2 restoring divider: 48-bit sum by 16-bit count, one quotient bit a cycle.
// Depends on moma_pkg.
module moma_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [moma_pkg::SumW-1:0]   i_num,
    input  logic [moma_pkg::CntW-1:0]   i_den,
    output logic                        o_done,
    output logic [moma_pkg::MeanW-1:0]  o_mean
);
    logic [moma_pkg::SumW-1:0]  r_q;
    logic [moma_pkg::CntW:0]    r_rem;
    logic [moma_pkg::CntW-1:0]  r_den;
    logic [moma_pkg::StepW-1:0] r_step;
    logic                       r_busy;
    logic [moma_pkg::CntW:0]    sh;
    logic [moma_pkg::CntW:0]    diff;

    assign sh   = {r_rem[moma_pkg::CntW-1:0], r_q[moma_pkg::SumW-1]};
    assign diff = sh - {1'b0, r_den};
    assign o_mean = (r_q[moma_pkg::SumW-1:moma_pkg::MeanW] != '0) ? '1
                    : r_q[moma_pkg::MeanW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_step <= moma_pkg::StepW'(moma_pkg::SumW);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (!diff[moma_pkg::CntW]) begin
                r_rem <= diff;
                r_q <= {r_q[moma_pkg::SumW-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q <= {r_q[moma_pkg::SumW-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && (r_step == moma_pkg::StepW'(1));
            if (i_start) r_busy <= 1'b1;
            else if (r_busy && r_step == moma_pkg::StepW'(1)) r_busy <= 1'b0;
        end
    end
endmodule

FILE: rtl/moma_back.sv
// Back end: clearing pass, insert read-modify-write, query divide/sort/median, bad-query reply.
// Depends on moma_pkg, moma_if, moma_ram, moma_div.
module moma_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  moma_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    output logic                 o_clr_busy,
    moma_out_if.source           out_ch
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_WR    = 8'b0000_1000,
        S_QRD   = 8'b0001_0000,
        S_QDIV  = 8'b0010_0000,
        S_QSORT = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [moma_pkg::AddrW-1:0] r_addr, r_caddr;
    logic [moma_pkg::SampW-1:0] r_sample;
    logic [moma_pkg::PixW-1:0] r_pix;
    logic [moma_pkg::BIdxW-1:0] r_slot;
    logic [moma_pkg::BIdxW-1:0] r_ins;
    logic r_rd_pend;
    logic r_empty;
    logic [moma_pkg::MeanW-1:0] r_m [moma_pkg::Buckets];
    logic [moma_pkg::MeanW-1:0] r_cur;
    logic [moma_pkg::SumW-1:0] sum_rd;
    logic [moma_pkg::CntW-1:0] cnt_rd;
    logic we;
    logic [moma_pkg::AddrW-1:0] waddr, raddr;
    logic [moma_pkg::SumW-1:0] wsum;
    logic [moma_pkg::CntW-1:0] wcnt;
    logic [moma_pkg::SumW:0] add;
    logic div_start, div_done;
    logic [moma_pkg::MeanW-1:0] div_mean;
    logic [moma_pkg::MeanW:0] midsum;
    logic sort_shift;
    logic take_badq;

    logic r_ovalid;
    logic [moma_pkg::PixW-1:0] r_opix;
    logic [moma_pkg::MeanW-1:0] r_omed;
    logic r_oempty;

    moma_ram #(.WIDTH(moma_pkg::SumW), .DEPTH(moma_pkg::RamDepth)) u_sums (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wsum),
        .i_raddr(raddr), .o_rdata(sum_rd));
    moma_ram #(.WIDTH(moma_pkg::CntW), .DEPTH(moma_pkg::RamDepth)) u_cnts (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wcnt),
        .i_raddr(raddr), .o_rdata(cnt_rd));
    moma_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(sum_rd), .i_den(cnt_rd), .o_done(div_done), .o_mean(div_mean));

    assign o_clr_busy = (r_state == S_CLEAR);
    assign add = {1'b0, sum_rd} + (moma_pkg::SumW+1)'(r_sample);
    assign midsum = (moma_pkg::Buckets % 2 == 0)
        ? {1'b0, r_m[moma_pkg::Buckets/2 - (1 - moma_pkg::Buckets % 2)]}
          + {1'b0, r_m[moma_pkg::Buckets/2]}
        : {r_m[moma_pkg::Buckets/2], 1'b0};
    assign sort_shift = (r_ins != '0) && (r_m[r_ins - 1'b1] > r_cur);
    assign take_badq = (r_state == S_IDLE) && i_cmd_valid
                       && (i_cmd.op == moma_pkg::OP_BADQ) && (!r_ovalid || out_ch.ready);
    assign out_ch.valid = r_ovalid;
    assign out_ch.pixel_index_out = r_opix;
    assign out_ch.median = r_omed;
    assign out_ch.empty_bucket = r_oempty;

    always_comb begin
        n_state = r_state;
        o_pop = 1'b0;
        we = 1'b0;
        waddr = r_addr;
        wsum = '0;
        wcnt = '0;
        raddr = r_addr;
        div_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                waddr = r_caddr;
                if (32'(r_caddr) == moma_pkg::RamDepth - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                raddr = i_cmd.addr;
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        moma_pkg::OP_INSERT: begin
                            o_pop = 1'b1;
                            n_state = S_RD;
                        end
                        moma_pkg::OP_QUERY: begin
                            if (!r_ovalid || out_ch.ready) begin
                                o_pop = 1'b1;
                                n_state = S_QRD;
                            end
                        end
                        moma_pkg::OP_BADQ: begin
                            if (!r_ovalid || out_ch.ready) o_pop = 1'b1;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                we = 1'b1;
                wsum = add[moma_pkg::SumW] ? moma_pkg::SumMax : add[moma_pkg::SumW-1:0];
                wcnt = (cnt_rd == moma_pkg::CntMax) ? cnt_rd : cnt_rd + 1'b1;
                n_state = S_IDLE;
            end
            S_QRD: begin
                if (r_rd_pend) begin
                    if (cnt_rd != '0) begin
                        div_start = 1'b1;
                        n_state = S_QDIV;
                    end else n_state = S_QSORT;
                end
            end
            S_QDIV: if (div_done) n_state = S_QSORT;
            S_QSORT: begin
                if (!sort_shift) begin
                    if (32'(r_slot) == moma_pkg::Buckets - 1) n_state = S_OUT;
                    else n_state = S_QRD;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_caddr <= '0;
            r_ovalid <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_caddr <= r_caddr + 1'b1;
            if (r_state == S_OUT || take_badq) r_ovalid <= 1'b1;
            else if (out_ch.ready) r_ovalid <= 1'b0;
            r_rd_pend <= (r_state == S_QRD) && !r_rd_pend;
        end
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_addr <= i_cmd.addr;
            r_sample <= i_cmd.sample;
            r_pix <= i_cmd.pix;
            r_slot <= '0;
            r_empty <= 1'b0;
            if (take_badq) begin
                r_opix <= i_cmd.pix;
                r_omed <= '0;
                r_oempty <= 1'b1;
            end
        end
        if (r_state == S_QRD && r_rd_pend) begin
            r_ins <= r_slot;
            if (cnt_rd == '0) begin
                r_cur <= '0;
                r_empty <= 1'b1;
            end
        end
        if (r_state == S_QDIV && div_done) r_cur <= div_mean;
        if (r_state == S_QSORT) begin
            if (sort_shift) begin
                r_m[r_ins] <= r_m[r_ins - 1'b1];
                r_ins <= r_ins - 1'b1;
            end else begin
                r_m[r_ins] <= r_cur;
                r_ins <= '0;
                r_slot <= r_slot + 1'b1;
                r_addr <= r_addr + 1'b1;
            end
        end
        if (r_state == S_OUT) begin
            r_opix <= r_pix;
            r_omed <= midsum[moma_pkg::MeanW:1];
            r_oempty <= r_empty;
        end
    end
endmodule
